### rtl/core/srpc_pkg.sv
// Shared types, constants and lookup tables of the stepper position ramp controller.
`default_nettype none

package srpc_pkg;

   localparam int SPEED_LEVELS = 256;
   localparam int SPEED_W      = $clog2(SPEED_LEVELS);
   localparam int POS_W        = 16;
   localparam int PERIOD_W     = 15;
   localparam int TORQUE_W     = 8;
   localparam int TABLE_DEPTH  = 256;
   localparam int X_SHIFT      = 2;
   localparam int Y_SHIFT      = 3;

   typedef struct packed {
      logic [POS_W-1:0] current_x;
      logic [POS_W-1:0] current_y;
      logic [POS_W-1:0] target_x;
      logic [POS_W-1:0] target_y;
   } req_word_type;

   typedef struct packed {
      logic                x_direction;
      logic [PERIOD_W-1:0] x_half_period;
      logic [TORQUE_W-1:0] x_torque;
      logic                y_direction;
      logic [PERIOD_W-1:0] y_half_period;
      logic [TORQUE_W-1:0] y_torque;
      logic                arrived;
   } rsp_word_type;

   typedef logic [POS_W-1:0] csr_word_type;

   // Per-axis decode of one request word, independent of the ramp state.
   typedef struct packed {
      logic               live;
      logic               in_window;
      logic               direction;
      logic [SPEED_W-1:0] goal;
   } axis_info_type;

   typedef struct packed {
      axis_info_type x;
      axis_info_type y;
   } stage_type;

   localparam logic [PERIOD_W-1:0] PERIOD_TABLE [TABLE_DEPTH] = '{
      15'd0,15'd31431,15'd30639,15'd29886,15'd29169,15'd28486,15'd27834,15'd27211,
      15'd26616,15'd26046,15'd25500,15'd24976,15'd24473,15'd23990,15'd23526,15'd23080,
      15'd22650,15'd22236,15'd21837,15'd21451,15'd21080,15'd20720,15'd20373,15'd20038,
      15'd19713,15'd19398,15'd19094,15'd18799,15'd18512,15'd18235,15'd17965,15'd17704,
      15'd17450,15'd17203,15'd16963,15'd16730,15'd16503,15'd16282,15'd16067,15'd15857,
      15'd15653,15'd15454,15'd15260,15'd15071,15'd14887,15'd14706,15'd14531,15'd14359,
      15'd14192,15'd14028,15'd13868,15'd13712,15'd13559,15'd13409,15'd13263,15'd13120,
      15'd12980,15'd12843,15'd12709,15'd12577,15'd12448,15'd12322,15'd12199,15'd12077,
      15'd11959,15'd11842,15'd11728,15'd11616,15'd11506,15'd11398,15'd11292,15'd11188,
      15'd11086,15'd10986,15'd10888,15'd10791,15'd10696,15'd10603,15'd10511,15'd10421,
      15'd10333,15'd10246,15'd10160,15'd10076,15'd9993,15'd9912,15'd9832,15'd9753,
      15'd9675,15'd9599,15'd9524,15'd9450,15'd9377,15'd9305,15'd9234,15'd9165,
      15'd9096,15'd9029,15'd8962,15'd8897,15'd8832,15'd8768,15'd8705,15'd8644,
      15'd8583,15'd8522,15'd8463,15'd8405,15'd8347,15'd8290,15'd8234,15'd8178,
      15'd8124,15'd8070,15'd8017,15'd7964,15'd7912,15'd7861,15'd7811,15'd7761,
      15'd7712,15'd7663,15'd7615,15'd7568,15'd7521,15'd7475,15'd7429,15'd7384,
      15'd7339,15'd7295,15'd7252,15'd7209,15'd7166,15'd7124,15'd7083,15'd7042,
      15'd7001,15'd6961,15'd6922,15'd6882,15'd6844,15'd6805,15'd6767,15'd6730,
      15'd6693,15'd6656,15'd6620,15'd6584,15'd6549,15'd6514,15'd6479,15'd6445,
      15'd6411,15'd6377,15'd6344,15'd6311,15'd6278,15'd6246,15'd6214,15'd6183,
      15'd6151,15'd6120,15'd6090,15'd6059,15'd6029,15'd6000,15'd5970,15'd5941,
      15'd5912,15'd5883,15'd5855,15'd5827,15'd5799,15'd5772,15'd5744,15'd5717,
      15'd5691,15'd5664,15'd5638,15'd5612,15'd5586,15'd5561,15'd5535,15'd5510,
      15'd5485,15'd5461,15'd5436,15'd5412,15'd5388,15'd5364,15'd5341,15'd5317,
      15'd5294,15'd5271,15'd5249,15'd5226,15'd5204,15'd5181,15'd5159,15'd5138,
      15'd5116,15'd5095,15'd5073,15'd5052,15'd5031,15'd5011,15'd4990,15'd4970,
      15'd4949,15'd4929,15'd4909,15'd4890,15'd4870,15'd4851,15'd4831,15'd4812,
      15'd4793,15'd4774,15'd4756,15'd4737,15'd4719,15'd4701,15'd4683,15'd4665,
      15'd4647,15'd4629,15'd4612,15'd4594,15'd4577,15'd4560,15'd4543,15'd4526,
      15'd4509,15'd4492,15'd4476,15'd4459,15'd4443,15'd4427,15'd4411,15'd4395,
      15'd4379,15'd4363,15'd4348,15'd4332,15'd4317,15'd4302,15'd4286,15'd4271,
      15'd4256,15'd4242,15'd4227,15'd4212,15'd4198,15'd4183,15'd4169,15'd4155
   };

   localparam logic [TORQUE_W-1:0] TORQUE_TABLE [TABLE_DEPTH] = '{
      8'd100,8'd100,8'd100,8'd101,8'd101,8'd101,8'd102,8'd102,
      8'd103,8'd103,8'd103,8'd104,8'd104,8'd105,8'd105,8'd105,
      8'd106,8'd106,8'd107,8'd107,8'd107,8'd108,8'd108,8'd108,
      8'd109,8'd109,8'd110,8'd110,8'd110,8'd111,8'd111,8'd112,
      8'd112,8'd112,8'd113,8'd113,8'd114,8'd114,8'd114,8'd115,
      8'd115,8'd116,8'd116,8'd116,8'd117,8'd117,8'd117,8'd118,
      8'd118,8'd119,8'd119,8'd119,8'd120,8'd120,8'd121,8'd121,
      8'd121,8'd122,8'd122,8'd123,8'd123,8'd123,8'd124,8'd124,
      8'd125,8'd125,8'd125,8'd126,8'd126,8'd126,8'd127,8'd127,
      8'd128,8'd128,8'd128,8'd129,8'd129,8'd130,8'd130,8'd130,
      8'd131,8'd131,8'd132,8'd132,8'd132,8'd133,8'd133,8'd133,
      8'd134,8'd134,8'd135,8'd135,8'd135,8'd136,8'd136,8'd137,
      8'd137,8'd137,8'd138,8'd138,8'd139,8'd139,8'd139,8'd140,
      8'd140,8'd141,8'd141,8'd141,8'd142,8'd142,8'd142,8'd143,
      8'd143,8'd144,8'd144,8'd144,8'd145,8'd145,8'd146,8'd146,
      8'd146,8'd147,8'd147,8'd148,8'd148,8'd148,8'd149,8'd149,
      8'd150,8'd150,8'd150,8'd151,8'd151,8'd151,8'd152,8'd152,
      8'd153,8'd153,8'd153,8'd154,8'd154,8'd155,8'd155,8'd155,
      8'd156,8'd156,8'd157,8'd157,8'd157,8'd158,8'd158,8'd158,
      8'd159,8'd159,8'd160,8'd160,8'd160,8'd161,8'd161,8'd162,
      8'd162,8'd162,8'd163,8'd163,8'd164,8'd164,8'd164,8'd165,
      8'd165,8'd166,8'd166,8'd166,8'd167,8'd167,8'd167,8'd168,
      8'd168,8'd169,8'd169,8'd169,8'd170,8'd170,8'd171,8'd171,
      8'd171,8'd172,8'd172,8'd173,8'd173,8'd173,8'd174,8'd174,
      8'd175,8'd175,8'd175,8'd176,8'd176,8'd176,8'd177,8'd177,
      8'd178,8'd178,8'd178,8'd179,8'd179,8'd180,8'd180,8'd180,
      8'd181,8'd181,8'd182,8'd182,8'd182,8'd183,8'd183,8'd183,
      8'd184,8'd184,8'd185,8'd185,8'd185,8'd186,8'd186,8'd187,
      8'd187,8'd187,8'd188,8'd188,8'd189,8'd189,8'd189,8'd190,
      8'd190,8'd191,8'd191,8'd191,8'd192,8'd192,8'd192,8'd193,
      8'd193,8'd194,8'd194,8'd194,8'd195,8'd195,8'd196,8'd196,
      8'd196,8'd197,8'd197,8'd198,8'd198,8'd198,8'd199,8'd199
   };

   // Window test, direction and saturated goal speed for one axis.
   function automatic axis_info_type axis_decode(
      input logic [POS_W-1:0] pos,
      input logic [POS_W-1:0] target,
      input logic [POS_W-1:0] tol,
      input int               shift
   );
      axis_info_type    info;
      logic [POS_W:0]   target_hi;
      logic [POS_W:0]   pos_hi;
      logic [POS_W-1:0] distance;
      logic [POS_W-1:0] scaled;
      target_hi      = {1'b0, target} + {1'b0, tol};
      pos_hi         = {1'b0, pos} + {1'b0, tol};
      info.live      = (pos != '0);
      info.in_window = ({1'b0, pos} < target_hi) && (pos_hi > {1'b0, target});
      if (target > pos) begin
         distance       = target - pos;
         info.direction = 1'b0;
      end else begin
         distance       = pos - target;
         info.direction = 1'b1;
      end
      scaled = distance >> shift;
      if (scaled > POS_W'(SPEED_LEVELS - 1)) begin
         info.goal = SPEED_W'(SPEED_LEVELS - 1);
      end else begin
         info.goal = scaled[SPEED_W-1:0];
      end
      return info;
   endfunction

endpackage

`default_nettype wire

### rtl/core/srpc_channels.sv
// Valid/ready channel interfaces for the request, response and register write words.
`default_nettype none

interface srpc_req_if;
   import srpc_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface srpc_rsp_if;
   import srpc_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface srpc_csr_if;
   import srpc_pkg::*;
   logic         valid;
   logic         ready;
   csr_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/core/srpc_front.sv
// Input stage: tolerance register and registered per-axis decode of each request word.
`default_nettype none

module srpc_front (
   input  wire                clock,
   input  wire                reset,
   srpc_req_if.sink           req_chan,
   srpc_csr_if.sink           csr_chan,
   input  wire                take,
   output logic               stage_valid,
   output srpc_pkg::stage_type stage_data
);
   import srpc_pkg::*;

   logic         s1_valid_ff;
   logic         s1_valid_in;
   stage_type    s1_data_ff;
   stage_type    s1_data_in;
   csr_word_type tol_ff;
   csr_word_type tol_in;
   logic         accept;

   assign req_chan.ready = !s1_valid_ff || take;
   assign csr_chan.ready = 1'b1;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_data_in.x = axis_decode(req_chan.payload.current_x, req_chan.payload.target_x,
                                 tol_ff, X_SHIFT);
      s1_data_in.y = axis_decode(req_chan.payload.current_y, req_chan.payload.target_y,
                                 tol_ff, Y_SHIFT);
      s1_valid_in  = accept || (s1_valid_ff && !take);
      tol_in       = (csr_chan.valid && csr_chan.ready) ? csr_chan.payload : tol_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         tol_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         tol_ff      <= tol_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff <= s1_data_in;
      end
   end

   assign stage_valid = s1_valid_ff;
   assign stage_data  = s1_data_ff;

endmodule

`default_nettype wire

### rtl/core/srpc_ramp.sv
// Ramp stage: speed index state, one-step ramp, table lookup and response register.
`default_nettype none

module srpc_ramp (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 stage_valid,
   input  srpc_pkg::stage_type stage_data,
   output logic                take,
   srpc_rsp_if.source          rsp_chan
);
   import srpc_pkg::*;

   logic [SPEED_W-1:0] x_speed_ff;
   logic [SPEED_W-1:0] x_speed_in;
   logic [SPEED_W-1:0] y_speed_ff;
   logic [SPEED_W-1:0] y_speed_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_word_type       rsp_word_ff;
   rsp_word_type       rsp_word_in;

   function automatic logic [SPEED_W-1:0] ramp_step(
      input axis_info_type      info,
      input logic [SPEED_W-1:0] speed
   );
      logic [SPEED_W-1:0] next;
      next = speed;
      if (info.live) begin
         if (info.in_window) begin
            next = '0;
         end else if (speed < info.goal) begin
            next = speed + 1'b1;
         end else if (speed > info.goal) begin
            next = speed - 1'b1;
         end
      end
      return next;
   endfunction

   assign take = stage_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      x_speed_in   = take ? ramp_step(stage_data.x, x_speed_ff) : x_speed_ff;
      y_speed_in   = take ? ramp_step(stage_data.y, y_speed_ff) : y_speed_ff;
      rsp_valid_in = take || (rsp_valid_ff && !rsp_chan.ready);

      rsp_word_in.x_direction   = stage_data.x.live && !stage_data.x.in_window &&
                                  stage_data.x.direction;
      rsp_word_in.x_half_period = PERIOD_TABLE[x_speed_in];
      rsp_word_in.x_torque      = TORQUE_TABLE[x_speed_in];
      rsp_word_in.y_direction   = stage_data.y.live && !stage_data.y.in_window &&
                                  stage_data.y.direction;
      rsp_word_in.y_half_period = PERIOD_TABLE[y_speed_in];
      rsp_word_in.y_torque      = TORQUE_TABLE[y_speed_in];
      rsp_word_in.arrived       = stage_data.x.live && stage_data.x.in_window &&
                                  stage_data.y.live && stage_data.y.in_window;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_speed_ff   <= '0;
         y_speed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         x_speed_ff   <= x_speed_in;
         y_speed_ff   <= y_speed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_word_ff;

`ifndef NO_ASSERTIONS
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      x_speed_ff <= SPEED_W'(SPEED_LEVELS - 1) && y_speed_ff <= SPEED_W'(SPEED_LEVELS - 1))
      else $error("speed index beyond the top speed level");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(x_speed_ff) && $stable(y_speed_ff))
      else $error("speed index moved without a word taken");

   a_window_stop: assert property (@(posedge clock) disable iff (reset)
      take && stage_data.x.live && stage_data.x.in_window |=> x_speed_ff == '0)
      else $error("X axis inside window did not stop");

   a_one_step: assert property (@(posedge clock) disable iff (reset)
      take && !stage_data.x.in_window |=>
         (x_speed_ff == $past(x_speed_ff)) ||
         (x_speed_ff == SPEED_W'($past(x_speed_ff) + 1'b1)) ||
         (x_speed_ff == SPEED_W'($past(x_speed_ff) - 1'b1)))
      else $error("X speed index moved by more than one step");

   a_arrived_stopped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.arrived |->
         rsp_word_ff.x_half_period == '0 && rsp_word_ff.y_half_period == '0)
      else $error("arrived reported with a running axis");
`endif

endmodule

`default_nettype wire

### rtl/core/stepper_position_ramp_controller.sv
// Top level of the two-axis stepper position ramp controller.
//
// Each request word on req_chan is one ramp tick and carries the measured and
// target X and Y positions. For every request word exactly one response word
// leaves on rsp_chan with the direction, step half period and torque of both
// axes and an arrived flag that is set when both axes are live and sit inside the window.
// The csr_chan port writes the position tolerance; it is always ready and
// should only be written while no word is in flight.
// The design is a two-register pipeline: the first register holds the decoded
// window test, direction and goal speed, the second holds the response word
// after the speed index has stepped and the tables have been read. A request
// word passes through the decode register and then the response register,
// and a new word can be taken every cycle while the receiver takes each
// response, so throughput is one word per clock in that case.
// When the receiver stalls, the response register holds its word and the
// first register takes one more word only if it is empty; then req_chan.ready
// drops until the response is taken. Reset clears both valid bits, both speed
// indexes and the tolerance; no clearing pass is needed.
`default_nettype none

module stepper_position_ramp_controller (
   input  wire        clock,
   input  wire        reset,
   srpc_req_if.sink   req_chan,
   srpc_rsp_if.source rsp_chan,
   srpc_csr_if.sink   csr_chan
);
   import srpc_pkg::*;

   // Handoff between the decode register and the ramp stage.
   logic      stage_valid;
   stage_type stage_data;
   logic      take;

   srpc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_chan    (csr_chan),
      .take        (take),
      .stage_valid (stage_valid),
      .stage_data  (stage_data)
   );

   // The ramp stage owns the speed state, so ticks are applied in arrival order.
   srpc_ramp u_ramp (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_data  (stage_data),
      .take        (take),
      .rsp_chan    (rsp_chan)
   );

endmodule

`default_nettype wire
